// ===== rtl/tli_pkg.sv =====
package tli_pkg;

    // Item kinds carried in the input tuser bit.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Region codes of a result.
    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_INSIDE = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    // Read address selection for both breakpoint memories.
    localparam logic [2:0] ADDR_ZERO = 3'd0;
    localparam logic [2:0] ADDR_HI   = 3'd1;
    localparam logic [2:0] ADDR_MID  = 3'd2;
    localparam logic [2:0] ADDR_LO   = 3'd3;
    localparam logic [2:0] ADDR_SCAN = 3'd4;

    // Source for the result register.
    localparam logic [1:0] RES_HOLD = 2'd0;
    localparam logic [1:0] RES_Y_LO = 2'd1;
    localparam logic [1:0] RES_Y_HI = 2'd2;
    localparam logic [1:0] RES_SUM  = 2'd3;

    // Fraction of the unit interval: 16 fraction bits, one integer bit.
    localparam int          FRAC_BITS = 16;
    localparam logic [16:0] FRAC_ONE  = 17'h1_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       start;
        logic       load;
        logic [2:0] rd_sel;
        logic       chk_first;
        logic       set_region;
        logic [1:0] region;
        logic       scan_issue;
        logic       bis_step;
        logic       latch_lo;
        logic       eval;
        logic       prep;
        logic       div_init;
        logic       div_step;
        logic       mul;
        logic       adj;
        logic [1:0] res_sel;
        logic       out_load;
    } tli_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt_first;
        logic gt_last;
        logic bis_go;
        logic scan_last;
        logic eq_hi;
        logic eq_lo;
        logic dx_zero;
        logic sign_diff;
        logic div_sat;
        logic div_last;
    } tli_status_t;

endpackage

// ===== rtl/tli_ctrl.sv =====
module tli_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_kind,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  tli_pkg::tli_status_t  status,
    output tli_pkg::tli_cmd_t     cmd
);
    import tli_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_RD_FIRST = 5'd1;
    localparam logic [4:0] ST_RD_LAST  = 5'd2;
    localparam logic [4:0] ST_CHK      = 5'd3;
    localparam logic [4:0] ST_SCAN     = 5'd4;
    localparam logic [4:0] ST_SCAN_END = 5'd5;
    localparam logic [4:0] ST_BIS      = 5'd6;
    localparam logic [4:0] ST_BIS_CMP  = 5'd7;
    localparam logic [4:0] ST_FETCH_HI = 5'd8;
    localparam logic [4:0] ST_EVAL     = 5'd9;
    localparam logic [4:0] ST_PREP     = 5'd10;
    localparam logic [4:0] ST_DIV_INIT = 5'd11;
    localparam logic [4:0] ST_DIV      = 5'd12;
    localparam logic [4:0] ST_MUL      = 5'd13;
    localparam logic [4:0] ST_ADJ      = 5'd14;
    localparam logic [4:0] ST_SUM      = 5'd15;
    localparam logic [4:0] ST_DONE     = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    // Input is taken only between queries; the output register is separate.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // Sequencer for one query.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = ADDR_ZERO;
        cmd.res_sel    = RES_HOLD;
        cmd.region     = REGION_INSIDE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_kind == KIND_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RD_FIRST;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_RD_FIRST:
            begin
                cmd.rd_sel = ADDR_ZERO;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.rd_sel    = ADDR_HI;
                cmd.chk_first = 1'b1;
                state_next    = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.set_region = 1'b1;
                priority if (status.lt_first)
                begin
                    cmd.region = REGION_BELOW;
                    state_next = ST_SCAN;
                end
                else if (status.gt_last)
                begin
                    cmd.region = REGION_ABOVE;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.region = REGION_INSIDE;
                    state_next = ST_BIS;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_sel     = ADDR_SCAN;
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_DONE;
            end
            ST_BIS:
            begin
                if (status.bis_go)
                begin
                    cmd.rd_sel = ADDR_MID;
                    state_next = ST_BIS_CMP;
                end
                else
                begin
                    cmd.rd_sel = ADDR_LO;
                    state_next = ST_FETCH_HI;
                end
            end
            ST_BIS_CMP:
            begin
                cmd.bis_step = 1'b1;
                state_next   = ST_BIS;
            end
            ST_FETCH_HI:
            begin
                cmd.rd_sel   = ADDR_HI;
                cmd.latch_lo = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                priority if (status.eq_hi)
                begin
                    cmd.res_sel = RES_Y_HI;
                    state_next  = ST_DONE;
                end
                else if (status.eq_lo || status.dx_zero || status.sign_diff)
                begin
                    cmd.res_sel = RES_Y_LO;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = status.div_sat ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                cmd.adj    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.res_sel = RES_SUM;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set on a load of the output register, cleared on a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/tli_dp.sv =====
module tli_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata,
    input  logic [5:0]            point_index,
    input  logic signed [31:0]    point_x,
    input  logic signed [31:0]    point_y,
    input  logic signed [31:0]    query_x,
    input  tli_pkg::tli_cmd_t     cmd,
    output tli_pkg::tli_status_t  status,
    output logic signed [31:0]    interp_y,
    output logic [1:0]            region
);
    import tli_pkg::*;

    localparam int          AW      = $clog2(MAX_POINTS);
    localparam logic [31:0] MAX_EXT = 32'(MAX_POINTS);
    localparam int          CNT_W   = $clog2(FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);
    localparam logic signed [35:0] SUM_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SUM_MIN = -36'sd2147483648;

    // Breakpoint memories.
    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [31:0] y_mem [MAX_POINTS];
    logic signed [31:0] x_rd_reg;
    logic signed [31:0] y_rd_reg;

    logic [6:0]          pts_reg;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    logic [AW-1:0]       k_reg, k_next;
    logic signed [31:0]  v_reg, v_next;
    logic                lt_first_reg, lt_first_next;
    logic [1:0]          region_reg, region_next;
    logic                sv_reg, sf_reg;
    logic signed [31:0]  xlo_reg, xlo_next;
    logic signed [31:0]  ylo_reg, ylo_next;
    logic signed [31:0]  yhi_reg, yhi_next;
    logic signed [32:0]  dv_reg, dv_next;
    logic signed [32:0]  dx_reg, dx_next;
    logic signed [32:0]  dy_reg, dy_next;
    logic                eq_hi_reg, eq_hi_next;
    logic                eq_lo_reg, eq_lo_next;
    logic [31:0]         adv_reg, adv_next;
    logic [31:0]         adx_reg, adx_next;
    logic [31:0]         rem_reg, rem_next;
    logic [16:0]         frac_reg, frac_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [50:0]  prod_reg, prod_next;
    logic signed [34:0]  scaled_reg, scaled_next;
    logic signed [31:0]  res_reg, res_next;
    logic signed [31:0]  out_y_reg, out_y_next;
    logic [1:0]          out_region_reg, out_region_next;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;
    logic [31:0]         idx_ext;
    logic [31:0]         pts_ext;
    logic [31:0]         last_ext;
    logic [AW:0]         mid_sum;
    logic [AW-1:0]       mid;
    logic signed [32:0]  dv_abs;
    logic signed [32:0]  dx_abs;
    logic [32:0]         rem_dbl;
    logic                rem_ge;
    logic signed [50:0]  prod_bias;
    logic signed [50:0]  prod_round;
    logic signed [35:0]  sum_wide;
    logic signed [31:0]  sum_sat;

    // Load address decode; entries beyond the table are dropped.
    assign idx_ext = 32'(point_index);
    assign wr_addr = idx_ext[AW-1:0];
    assign wr_en   = cmd.load && (idx_ext < MAX_EXT);

    // Last used entry, from the point count clamped to between two and the table size.
    always_comb
    begin
        pts_ext = 32'(pts_reg);
        if (pts_ext < 32'd2)
        begin
            last_ext = 32'd1;
        end
        else if (pts_ext > MAX_EXT)
        begin
            last_ext = MAX_EXT - 32'd1;
        end
        else
        begin
            last_ext = pts_ext - 32'd1;
        end
    end

    // Bisection midpoint.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AW:1];

    // Read address selection, shared by both memories.
    always_comb
    begin
        unique case (cmd.rd_sel)
            ADDR_ZERO: rd_addr = '0;
            ADDR_HI:   rd_addr = hi_reg;
            ADDR_MID:  rd_addr = mid;
            ADDR_LO:   rd_addr = lo_reg;
            ADDR_SCAN: rd_addr = k_reg;
            default:   rd_addr = '0;
        endcase
    end

    // Memories: one write and one registered read a cycle each.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= point_x;
            y_mem[wr_addr] <= point_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // Divider step and result arithmetic.
    assign dv_abs     = dv_reg[32] ? -dv_reg : dv_reg;
    assign dx_abs     = dx_reg[32] ? -dx_reg : dx_reg;
    assign rem_dbl    = {rem_reg, 1'b0};
    assign rem_ge     = rem_dbl >= {1'b0, adx_reg};
    assign prod_bias  = prod_reg[50] ? 51'sd65535 : 51'sd0;
    assign prod_round = prod_reg + prod_bias;
    assign sum_wide   = 36'(ylo_reg) + 36'(scaled_reg);

    always_comb
    begin
        if (sum_wide > SUM_MAX)
        begin
            sum_sat = 32'sh7FFF_FFFF;
        end
        else if (sum_wide < SUM_MIN)
        begin
            sum_sat = 32'sh8000_0000;
        end
        else
        begin
            sum_sat = sum_wide[31:0];
        end
    end

    // Next values of the working registers.
    always_comb
    begin
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        k_next          = k_reg;
        v_next          = v_reg;
        lt_first_next   = lt_first_reg;
        region_next     = region_reg;
        xlo_next        = xlo_reg;
        ylo_next        = ylo_reg;
        yhi_next        = yhi_reg;
        dv_next         = dv_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        eq_hi_next      = eq_hi_reg;
        eq_lo_next      = eq_lo_reg;
        adv_next        = adv_reg;
        adx_next        = adx_reg;
        rem_next        = rem_reg;
        frac_next       = frac_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        scaled_next     = scaled_reg;
        res_next        = res_reg;
        out_y_next      = out_y_reg;
        out_region_next = out_region_reg;

        if (cmd.start)
        begin
            v_next  = query_x;
            lo_next = '0;
            hi_next = last_ext[AW-1:0];
            k_next  = '0;
        end
        if (cmd.chk_first)
        begin
            lt_first_next = v_reg < x_rd_reg;
        end
        if (cmd.set_region)
        begin
            region_next = cmd.region;
        end

        // Minimum or maximum scan over the used entries.
        if (cmd.scan_issue)
        begin
            k_next = k_reg + 1'b1;
        end
        if (sv_reg)
        begin
            if (sf_reg)
            begin
                res_next = y_rd_reg;
            end
            else if (region_reg == REGION_BELOW)
            begin
                if (y_rd_reg < res_reg)
                begin
                    res_next = y_rd_reg;
                end
            end
            else if (y_rd_reg > res_reg)
            begin
                res_next = y_rd_reg;
            end
        end

        // Bisection narrows the bracket by one entry read.
        if (cmd.bis_step)
        begin
            if (v_reg < x_rd_reg)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid;
            end
        end

        // Bracketing entries and their differences.
        if (cmd.latch_lo)
        begin
            xlo_next = x_rd_reg;
            ylo_next = y_rd_reg;
        end
        if (cmd.eval)
        begin
            dv_next    = 33'(v_reg) - 33'(xlo_reg);
            dx_next    = 33'(x_rd_reg) - 33'(xlo_reg);
            dy_next    = 33'(y_rd_reg) - 33'(ylo_reg);
            yhi_next   = y_rd_reg;
            eq_hi_next = v_reg == x_rd_reg;
            eq_lo_next = v_reg == xlo_reg;
        end
        if (cmd.prep)
        begin
            adv_next = dv_abs[31:0];
            adx_next = dx_abs[31:0];
        end

        // Restoring division of |dv| * 2^16 by |dx|, one quotient bit a cycle.
        // A quotient of one or more saturates to the whole interval at once.
        if (cmd.div_init)
        begin
            cnt_next = '0;
            if (status.div_sat)
            begin
                frac_next = FRAC_ONE;
                rem_next  = adv_reg;
            end
            else
            begin
                frac_next = 17'd0;
                rem_next  = adv_reg;
            end
        end
        if (cmd.div_step)
        begin
            cnt_next  = cnt_reg + 1'b1;
            frac_next = {frac_reg[15:0], rem_ge};
            if (rem_ge)
            begin
                rem_next = 32'(rem_dbl - {1'b0, adx_reg});
            end
            else
            begin
                rem_next = rem_dbl[31:0];
            end
        end

        // Scale the ordinate step, truncating toward zero.
        if (cmd.mul)
        begin
            prod_next = 51'($signed(dy_reg) * $signed({1'b0, frac_reg}));
        end
        if (cmd.adj)
        begin
            scaled_next = prod_round[50:16];
        end

        unique case (cmd.res_sel)
            RES_HOLD: ;
            RES_Y_LO: res_next = ylo_reg;
            RES_Y_HI: res_next = yhi_reg;
            RES_SUM:  res_next = sum_sat;
            default:  ;
        endcase

        if (cmd.out_load)
        begin
            out_y_next      = res_reg;
            out_region_next = region_reg;
        end
    end

    // Configuration and scan control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= 7'd2;
            sv_reg  <= 1'b0;
            sf_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pts_reg <= cfg_wdata;
            end
            sv_reg <= cmd.scan_issue;
            sf_reg <= cmd.scan_issue && (k_reg == '0);
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        k_reg          <= k_next;
        v_reg          <= v_next;
        lt_first_reg   <= lt_first_next;
        region_reg     <= region_next;
        xlo_reg        <= xlo_next;
        ylo_reg        <= ylo_next;
        yhi_reg        <= yhi_next;
        dv_reg         <= dv_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        eq_hi_reg      <= eq_hi_next;
        eq_lo_reg      <= eq_lo_next;
        adv_reg        <= adv_next;
        adx_reg        <= adx_next;
        rem_reg        <= rem_next;
        frac_reg       <= frac_next;
        cnt_reg        <= cnt_next;
        prod_reg       <= prod_next;
        scaled_reg     <= scaled_next;
        res_reg        <= res_next;
        out_y_reg      <= out_y_next;
        out_region_reg <= out_region_next;
    end

    // Status back to the controller.
    always_comb
    begin
        status.lt_first  = lt_first_reg;
        status.gt_last   = v_reg > x_rd_reg;
        status.bis_go    = {1'b0, hi_reg} > ({1'b0, lo_reg} + 1'b1);
        status.scan_last = k_reg == hi_reg;
        status.eq_hi     = eq_hi_reg;
        status.eq_lo     = eq_lo_reg;
        status.dx_zero   = dx_reg == '0;
        status.sign_diff = dv_reg[32] ^ dx_reg[32];
        status.div_sat   = adv_reg >= adx_reg;
        status.div_last  = cnt_reg == CNT_LAST;
    end

    assign interp_y = out_y_reg;
    assign region   = out_region_reg;

endmodule

// ===== rtl/table_linear_interpolator_top.sv =====
// Channel   Dir  Bits                      Fields, lowest bit first
// s_tdata   in   104 (102 used)            point_index[5:0], point_x, point_y, query_x
// s_tuser   in   1                         kind (0 load, 1 query)
// m_tdata   out  32                        interp_y
// m_tuser   out  2                         region (0 below, 1 inside, 2 above)
// cfg       in   7                         points_in_use, written when cfg_we is high
//
// A load is written as it is taken and leaves the block idle. A query inside the table bisects
// for its bracket (six steps for 64 points), then the serial divider; a breakpoint hit, equal
// abscissas or a negative fraction skip the divider, and a saturated fraction skips its steps.
// A query outside the table runs a min or max scan over the used points.
// Reset clears the sequencer and output valid flag and sets points_in_use to 2. The next item is
// taken the cycle after a result is registered; a later result waits for that transfer.
module table_linear_interpolator_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // point_index, point_x, point_y, query_x, zero pad
    input  logic [0:0]    s_tuser,   // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // interp_y
    output logic [1:0]    m_tuser,   // region
    input  logic          cfg_we,
    input  logic [6:0]    cfg_wdata
);
    import tli_pkg::*;

    tli_cmd_t           cmd;
    tli_status_t        status;
    logic signed [31:0] interp_y;
    logic [1:0]         region;

    // Sequencer.
    tli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Memories, divider and arithmetic.
    tli_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .point_index (s_tdata[5:0]),
        .point_x     (s_tdata[37:6]),
        .point_y     (s_tdata[69:38]),
        .query_x     (s_tdata[101:70]),
        .cmd         (cmd),
        .status      (status),
        .interp_y    (interp_y),
        .region      (region)
    );

    assign m_tdata = interp_y;
    assign m_tuser = region;

    // A query transfer starts a run that blocks further input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == KIND_QUERY)) |=> !s_tready)
        else $error("query did not start the sequencer");

    // A load transfer leaves the block ready for the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == KIND_LOAD)) |=> s_tready)
        else $error("load transfer left the idle state");

    // The output register is never overwritten while its result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // A presented result carries a defined region code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == REGION_BELOW) || (m_tuser == REGION_INSIDE) ||
                      (m_tuser == REGION_ABOVE)))
        else $error("undefined region code on output");

endmodule
